// ===== rtl/core/sia_pkg.sv =====
package sia_pkg;

	// Default datapath width.
	localparam int DefaultWidth = 64;

	// Operation codes.
	localparam logic [4:0] OP_OR    = 5'd0;
	localparam logic [4:0] OP_AND   = 5'd1;
	localparam logic [4:0] OP_XOR   = 5'd2;
	localparam logic [4:0] OP_EQ    = 5'd3;
	localparam logic [4:0] OP_NE    = 5'd4;
	localparam logic [4:0] OP_LT    = 5'd5;
	localparam logic [4:0] OP_GT    = 5'd6;
	localparam logic [4:0] OP_LE    = 5'd7;
	localparam logic [4:0] OP_GE    = 5'd8;
	localparam logic [4:0] OP_PASS  = 5'd9;
	localparam logic [4:0] OP_SHL   = 5'd10;
	localparam logic [4:0] OP_SAR   = 5'd11;
	localparam logic [4:0] OP_ADD   = 5'd12;
	localparam logic [4:0] OP_SUB   = 5'd13;
	localparam logic [4:0] OP_MUL   = 5'd14;
	localparam logic [4:0] OP_DIV   = 5'd15;
	localparam logic [4:0] OP_REM   = 5'd16;
	localparam logic [4:0] OP_LOR   = 5'd17;
	localparam logic [4:0] OP_LAND  = 5'd18;
	localparam logic [4:0] OP_LNOT  = 5'd19;
	localparam logic [4:0] OP_INV   = 5'd20;
	localparam logic [4:0] OP_NEG   = 5'd21;
	localparam logic [4:0] OP_PLUS  = 5'd22;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADOP   = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	// Which result the back end picks.
	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_MUL    = 2'd1;
	localparam logic [1:0] KIND_DIV    = 2'd2;
	localparam logic [1:0] KIND_REM    = 2'd3;

	// Control that travels with each word down the chain.
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic       quo_neg;
		logic       rem_neg;
		logic [1:0] status;
	} ctl_t;

endpackage

// ===== rtl/core/sia_front.sv =====
module sia_front #(
	parameter int DATA_WIDTH = sia_pkg::DefaultWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [4:0]            op,
	input  logic [63:0]           left_operand,
	input  logic [63:0]           right_operand,
	output sia_pkg::ctl_t         ctl_s1,
	output logic [DATA_WIDTH-1:0] simple_s1,
	output logic [DATA_WIDTH-1:0] mcand_s1,
	output logic [DATA_WIDTH-1:0] mplier_s1,
	output logic [DATA_WIDTH-1:0] dvd_s1,
	output logic [DATA_WIDTH-1:0] dvs_s1
);
	import sia_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0] a, b, res, ua, ub;
	logic [5:0]   sh;
	logic         a_neg, b_neg, a_nz, b_nz, lt, gt;
	ctl_t         ctl;

	assign a     = left_operand[W-1:0];
	assign b     = right_operand[W-1:0];
	assign sh    = b[5:0];
	assign a_neg = a[W-1];
	assign b_neg = b[W-1];
	assign a_nz  = |a;
	assign b_nz  = |b;
	assign lt    = $signed(a) < $signed(b);
	assign gt    = $signed(b) < $signed(a);
	assign ua    = a_neg ? W'(-a) : a;
	assign ub    = b_neg ? W'(-b) : b;

	// Operations computed in the front stage, and the routing of multiply, divide and remainder.
	always_comb begin
		res          = '0;
		ctl.valid    = in_valid;
		ctl.kind     = KIND_SIMPLE;
		ctl.quo_neg  = a_neg ^ b_neg;
		ctl.rem_neg  = a_neg;
		ctl.status   = ST_OK;
		case (op)
			OP_OR:   res = a | b;
			OP_AND:  res = a & b;
			OP_XOR:  res = a ^ b;
			OP_EQ:   res = W'(a == b);
			OP_NE:   res = W'(a != b);
			OP_LT:   res = W'(lt);
			OP_GT:   res = W'(gt);
			OP_LE:   res = W'(!gt);
			OP_GE:   res = W'(!lt);
			OP_PASS: res = b;
			OP_SHL:  res = a << sh;
			OP_SAR:  res = W'($signed(a) >>> sh);
			OP_ADD:  res = a + b;
			OP_SUB:  res = a - b;
			OP_MUL:  ctl.kind = KIND_MUL;
			OP_DIV, OP_REM: begin
				if (!b_nz) begin
					ctl.status = ST_DIVZERO;
				end else begin
					ctl.kind = (op == OP_DIV) ? KIND_DIV : KIND_REM;
				end
			end
			OP_LOR:  res = W'(a_nz || b_nz);
			OP_LAND: res = W'(a_nz && b_nz);
			OP_LNOT: res = W'(!a_nz);
			OP_INV:  res = ~a;
			OP_NEG:  res = W'(-a);
			OP_PLUS: res = a;
			default: ctl.status = ST_BADOP;
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			simple_s1 <= res;
			mcand_s1  <= a;
			mplier_s1 <= b;
			dvd_s1    <= ua;
			dvs_s1    <= ub;
		end
	end

endmodule

// ===== rtl/core/sia_cell.sv =====
module sia_cell #(
	parameter int DATA_WIDTH = sia_pkg::DefaultWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  sia_pkg::ctl_t         ctl_i,
	input  logic [DATA_WIDTH-1:0] simple_i,
	input  logic [DATA_WIDTH-1:0] mcand_i,
	input  logic [DATA_WIDTH-1:0] mplier_i,
	input  logic [DATA_WIDTH-1:0] prod_i,
	input  logic [DATA_WIDTH-1:0] dvd_i,
	input  logic [DATA_WIDTH-1:0] dvs_i,
	input  logic [DATA_WIDTH-1:0] rem_i,
	output sia_pkg::ctl_t         ctl_q,
	output logic [DATA_WIDTH-1:0] simple_q,
	output logic [DATA_WIDTH-1:0] mcand_q,
	output logic [DATA_WIDTH-1:0] mplier_q,
	output logic [DATA_WIDTH-1:0] prod_q,
	output logic [DATA_WIDTH-1:0] dvd_q,
	output logic [DATA_WIDTH-1:0] dvs_q,
	output logic [DATA_WIDTH-1:0] rem_q
);
	import sia_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0] trial, prod_n;
	logic         fits;

	// One restoring division step: the quotient bit enters the dividend's low end.
	assign trial  = {rem_i[W-2:0], dvd_i[W-1]};
	assign fits   = trial >= dvs_i;
	// One shift-and-add multiply step.
	assign prod_n = mplier_i[0] ? prod_i + mcand_i : prod_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			simple_q <= simple_i;
			mcand_q  <= {mcand_i[W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_i[W-1:1]};
			prod_q   <= prod_n;
			dvd_q    <= {dvd_i[W-2:0], fits};
			dvs_q    <= dvs_i;
			rem_q    <= fits ? trial - dvs_i : trial;
		end
	end

endmodule

// ===== rtl/core/sia_back.sv =====
module sia_back #(
	parameter int DATA_WIDTH = sia_pkg::DefaultWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  sia_pkg::ctl_t         ctl_i,
	input  logic [DATA_WIDTH-1:0] simple_i,
	input  logic [DATA_WIDTH-1:0] prod_i,
	input  logic [DATA_WIDTH-1:0] quo_i,
	input  logic [DATA_WIDTH-1:0] rem_i,
	output logic                  out_valid,
	output logic [63:0]           result,
	output logic [1:0]            status
);
	import sia_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0] res, res_q;
	logic [1:0]   status_q;
	logic         valid_q;

	// Pick the result and apply the sign of the quotient or remainder.
	always_comb begin
		case (ctl_i.kind)
			KIND_SIMPLE: res = simple_i;
			KIND_MUL:    res = prod_i;
			KIND_DIV:    res = ctl_i.quo_neg ? W'(-quo_i) : quo_i;
			KIND_REM:    res = ctl_i.rem_neg ? W'(-rem_i) : rem_i;
			default:     res = '0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q    <= res;
			status_q <= ctl_i.status;
		end
	end

	assign out_valid = valid_q;
	assign result    = 64'($signed(res_q));
	assign status    = status_q;

endmodule

// ===== rtl/core/signed_integer_alu_core.sv =====
// Channel | Direction | Signals
// input   | in        | in_valid, in_stall, op, left_operand, right_operand
// output  | out       | out_valid, out_stall, result, status
//
// One word is accepted per cycle while in_stall is low; its result passes through
// the input register, the chain of cells and the output register.
// The chain holds DATA_WIDTH cells, each doing one divide step
// and one multiply step, between the input register and the output register.
// Reset clears all valid flags; data registers are not reset.
// A stalled output word freezes the whole chain, and in_stall follows it.
module signed_integer_alu_core #(
	parameter int DATA_WIDTH = sia_pkg::DefaultWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  op,
	input  logic [63:0] left_operand,
	input  logic [63:0] right_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result,
	output logic [1:0]  status
);
	import sia_pkg::*;

	localparam int W = DATA_WIDTH;

	logic adv;

	ctl_t         ctl_c    [0:W];
	logic [W-1:0] simple_c [0:W];
	logic [W-1:0] mcand_c  [0:W];
	logic [W-1:0] mplier_c [0:W];
	logic [W-1:0] prod_c   [0:W];
	logic [W-1:0] dvd_c    [0:W];
	logic [W-1:0] dvs_c    [0:W];
	logic [W-1:0] rem_c    [0:W];

	// The chain moves unless a finished word is held at the output.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign prod_c[0] = '0;
	assign rem_c[0]  = '0;

	sia_front #(.DATA_WIDTH(W)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.op           (op),
		.left_operand (left_operand),
		.right_operand(right_operand),
		.ctl_s1       (ctl_c[0]),
		.simple_s1    (simple_c[0]),
		.mcand_s1     (mcand_c[0]),
		.mplier_s1    (mplier_c[0]),
		.dvd_s1       (dvd_c[0]),
		.dvs_s1       (dvs_c[0])
	);

	// Row of step cells.
	for (genvar k = 0; k < W; k++) begin : g_cell
		sia_cell #(.DATA_WIDTH(W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_i   (ctl_c[k]),
			.simple_i(simple_c[k]),
			.mcand_i (mcand_c[k]),
			.mplier_i(mplier_c[k]),
			.prod_i  (prod_c[k]),
			.dvd_i   (dvd_c[k]),
			.dvs_i   (dvs_c[k]),
			.rem_i   (rem_c[k]),
			.ctl_q   (ctl_c[k+1]),
			.simple_q(simple_c[k+1]),
			.mcand_q (mcand_c[k+1]),
			.mplier_q(mplier_c[k+1]),
			.prod_q  (prod_c[k+1]),
			.dvd_q   (dvd_c[k+1]),
			.dvs_q   (dvs_c[k+1]),
			.rem_q   (rem_c[k+1])
		);
	end

	sia_back #(.DATA_WIDTH(W)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_i    (ctl_c[W]),
		.simple_i (simple_c[W]),
		.prod_i   (prod_c[W]),
		.quo_i    (dvd_c[W]),
		.rem_i    (rem_c[W]),
		.out_valid(out_valid),
		.result   (result),
		.status   (status)
	);

endmodule

// ===== rtl/core/sia_checker.sv =====
module sia_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result,
	input logic [1:0]  status
);
	import sia_pkg::*;

	// A held output word stays valid.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("output word dropped");

	// A held output word keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result) && $stable(status))
		else $error("held output word changed");

	// Input backpressure only comes from a held output word.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("input stalled without cause");

	// Only defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_BADOP || status == ST_DIVZERO)
		else $error("undefined status code");

	// A division-by-zero or bad-op word carries a zero result.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result == 64'd0)
		else $error("error word with nonzero result");

endmodule

bind signed_integer_alu_core sia_checker u_sia_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.result   (result),
	.status   (status)
);

// ===== tb/signed_integer_alu_core_tb.sv =====
module signed_integer_alu_core_tb;
	import sia_pkg::*;

	localparam int PIPE_DEPTH = 66;

	// Expected result of one operation.
	typedef struct {
		logic [63:0] value;
		logic [1:0]  code;
	} alu_result_t;

	// Scoreboard: predicts each accepted word and checks results in order.
	class alu_scoreboard;
		alu_result_t pending[$];
		int          errors;

		function automatic alu_result_t compute(logic [4:0] opc, logic [63:0] a,
			logic [63:0] b);
			alu_result_t r;
			logic [63:0] ua, ub, q;
			logic [5:0]  sh;
			sh = b[5:0];
			r.value = '0;
			r.code = ST_OK;
			case (opc)
				OP_OR:   r.value = a | b;
				OP_AND:  r.value = a & b;
				OP_XOR:  r.value = a ^ b;
				OP_EQ:   r.value = 64'(a == b);
				OP_NE:   r.value = 64'(a != b);
				OP_LT:   r.value = 64'($signed(a) < $signed(b));
				OP_GT:   r.value = 64'($signed(a) > $signed(b));
				OP_LE:   r.value = 64'($signed(a) <= $signed(b));
				OP_GE:   r.value = 64'($signed(a) >= $signed(b));
				OP_PASS: r.value = b;
				OP_SHL:  r.value = a << sh;
				OP_SAR:  r.value = $signed(a) >>> sh;
				OP_ADD:  r.value = a + b;
				OP_SUB:  r.value = a - b;
				OP_MUL:  r.value = a * b;
				OP_DIV, OP_REM: begin
					if (b == 0) begin
						r.code = ST_DIVZERO;
					end else begin
						// Work on magnitudes, then restore the sign.
						ua = a[63] ? -a : a;
						ub = b[63] ? -b : b;
						if (opc == OP_DIV) begin
							q = ua / ub;
							r.value = (a[63] != b[63]) ? -q : q;
						end else begin
							q = ua % ub;
							r.value = a[63] ? -q : q;
						end
					end
				end
				OP_LOR:  r.value = 64'((a != 0) || (b != 0));
				OP_LAND: r.value = 64'((a != 0) && (b != 0));
				OP_LNOT: r.value = 64'(a == 0);
				OP_INV:  r.value = ~a;
				OP_NEG:  r.value = -a;
				OP_PLUS: r.value = a;
				default: r.code = ST_BADOP;
			endcase
			return r;
		endfunction

		function void note_operation(logic [4:0] opc, logic [63:0] a, logic [63:0] b);
			pending.push_back(compute(opc, a, b));
		endfunction

		function void check_result(logic [63:0] v, logic [1:0] c);
			alu_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result value %h status %0d", v, c);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$error("result expected %h actual %h", e.value, v);
				errors++;
			end
			if (c !== e.code) begin
				$error("status expected %0d actual %0d", e.code, c);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [4:0]  op = '0;
	logic [63:0] left_operand = '0;
	logic [63:0] right_operand = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result;
	logic [1:0]  status;

	alu_scoreboard board = new();
	bit            quiet_phase = 1'b0;
	bit            hold_request = 1'b0;
	bit            stimulus_done = 1'b0;

	signed_integer_alu_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .left_operand(left_operand), .right_operand(right_operand),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .status(status)
	);

	always #6 clk = ~clk;

	// Offer one word, with a random idle gap before it outside quiet stretches, and wait for acceptance.
	task automatic send_word(logic [4:0] opc, logic [63:0] a, logic [63:0] b);
		while (!quiet_phase && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		left_operand <= a;
		right_operand <= b;
		do @(posedge clk); while (in_stall);
		board.note_operation(opc, a, b);
	endtask

	// Operand values biased toward the edges.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(7))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return 64'(signed'($urandom_range(20)) - 10);
			4: return 64'($urandom);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Receiver: random stall, except during quiet stretches and forced holds.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_result(result, status);
		out_stall <= hold_request || (!quiet_phase && $urandom_range(99) < 21);
	end

	// Long receiver hold, counted here, so the chain freezes and stalls input.
	initial begin
		int n;
		wait (arst_n);
		repeat (150) @(posedge clk);
		hold_request = 1'b1;
		for (n = 0; n < 200; n++)
			@(posedge clk);
		hold_request = 1'b0;
	end

	// Stimulus.
	initial begin
		logic [63:0] edges[6];
		int i;
		edges = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, '1, 0, 1, 64'd64};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Every code with edge operands.
		for (i = 0; i < 32; i++)
			send_word(5'(i), edges[i % 6], edges[(i + 2) % 6]);
		send_word(OP_DIV, 64'h8000_0000_0000_0000, '1);
		send_word(OP_REM, 64'h8000_0000_0000_0000, '1);
		send_word(OP_DIV, 64'd7, '0);
		send_word(OP_SHL, 64'd3, 64'd63);
		send_word(OP_SAR, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ff7f);
		// Random words; the middle stretch runs without idling.
		for (i = 0; i < 400; i++) begin
			quiet_phase = (i >= 150 && i < 230);
			send_word(($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
				5'($urandom_range(22)), pick_operand(), pick_operand());
		end
		quiet_phase = 1'b0;
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// End of run once the scoreboard drains.
	initial begin
		wait (stimulus_done);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Timeout.
	initial begin
		#600000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
